### rtl/pts_pkg.sv
// Shared types and constants for the priority task scheduler.
// Holds the task table entry layout, event codes and sizing constants.
// Has no dependencies.
package pts_pkg;

  // Number of task slots in the table and the widths that follow from it.
  localparam int TASK_SLOTS = 8;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  // A priority of this value is never scheduled.
  localparam logic [7:0] PRIO_NEVER = 8'd255;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Event kinds carried by a request.
  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_DELAY  = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  // Task status codes.
  typedef enum logic [1:0] {
    ST_SUSPENDED = 2'd0,
    ST_READY     = 2'd1,
    ST_RUNNING   = 2'd2,
    ST_WAITING   = 2'd3
  } status_t;

  // One task table entry as held in the table memory.
  typedef struct packed {
    logic [7:0]  prio;
    status_t     status;
    logic [15:0] ticks;
    logic        active;
  } entry_t;

  // Contents of a table entry that has never been written.
  localparam entry_t ENTRY_RESET = '{prio: PRIO_NEVER, status: ST_SUSPENDED,
                                     ticks: 16'd0, active: 1'b0};

endpackage

### rtl/priority_task_scheduler.sv
// An accepted request walks every table entry in order, writes back the demoted and the
// promoted task, then loads the result once the output register is free; the sequencer is
// idle again only after that and only then takes a new request, set by the single table port.
// A finished result waits in an output register while the next request is accepted.
// Reset (rst_n low, synchronous) empties the table through per-entry valid bits,
// so no clearing pass is needed and a request can be taken in the first cycle after.

// Top level of the priority task scheduler: task table memory and event sequencer.
// Depends on pts_pkg for the entry layout, codes and sizing constants.
module priority_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // task_id [2:0], priority_req [10:3], delay_ticks [26:11]
  input  logic [1:0]  in_tuser,   // mode [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // running_task [2:0], task_valid [3], tick_enable [4]
);
  import pts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_WALK    = 5'b00010,
    S_DEMOTE  = 5'b00100,
    S_PROMOTE = 5'b01000,
    S_OUT     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Latched request.
  mode_t       ev_mode_r;
  logic [2:0]  ev_id_r;
  logic [7:0]  ev_prio_r;
  logic [15:0] ev_dly_r;

  // Task table memory with valid bits standing in for the reset contents.
  entry_t mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] vld_r;
  entry_t rd_r;
  logic   rd_vld_r;
  slot_t  rd_addr;

  logic   we;
  slot_t  wa;
  entry_t wd;

  // Walk and selection state.
  slot_t  pk_r;
  slot_t  best_r;
  entry_t best_ent_r;
  logic   found_r;
  entry_t cur_ent_r;
  slot_t  cur_task_r;
  logic   cur_valid_r;
  cnt_t   cnt_r, cnt_nxt;

  logic       out_tvalid_r;
  logic [7:0] out_data_r;

  entry_t eff, upd;
  logic   id_ok, elig, do_demote, in_req, out_free;

  assign in_req    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;
  assign id_ok     = (32'(ev_id_r) < TASK_SLOTS);

  // An entry never written reads as its reset contents.
  assign eff = rd_vld_r ? rd_r : ENTRY_RESET;

  // Apply the current event to the entry being walked.
  always_comb begin
    upd     = eff;
    cnt_nxt = cnt_r;
    case (ev_mode_r)
      MODE_CREATE: begin
        if (id_ok && (pk_r == slot_t'(ev_id_r))) begin
          upd.prio   = ev_prio_r;
          upd.status = ST_READY;
        end
      end
      MODE_DELAY: begin
        if (cur_valid_r && (pk_r == cur_task_r)) begin
          upd.status = ST_WAITING;
          upd.ticks  = ev_dly_r;
          if (!eff.active) begin
            upd.active = 1'b1;
            cnt_nxt    = CNT_W'(cnt_r + 1'b1);
          end
        end
      end
      MODE_DELETE: begin
        if (cur_valid_r && (pk_r == cur_task_r)) begin
          upd.status = ST_SUSPENDED;
        end
      end
      MODE_TICK: begin
        if (eff.active) begin
          upd.ticks = 16'(eff.ticks - 16'd1);
          if (upd.ticks == 16'd0) begin
            upd.status = ST_READY;
            upd.active = 1'b0;
            if (cnt_r != '0) begin
              cnt_nxt = CNT_W'(cnt_r - 1'b1);
            end
          end
        end
      end
      default: begin
        upd = eff;
      end
    endcase
  end

  // Strict compare keeps the lowest index on equal priority.
  assign elig = ((upd.status == ST_READY) || (upd.status == ST_RUNNING)) &&
                (upd.prio < best_ent_r.prio);

  // The previous running task goes back to ready when another one wins.
  assign do_demote = found_r && cur_valid_r && (cur_task_r != best_r) &&
                     (cur_ent_r.status == ST_RUNNING);

  // Read address: entry 0 on acceptance, the next entry during the walk.
  assign rd_addr = (state_r == S_IDLE) ? '0 : slot_t'(pk_r + 1'b1);

  // Table write port selection.
  always_comb begin
    we = 1'b0;
    wa = pk_r;
    wd = upd;
    case (state_r)
      S_WALK: begin
        we = 1'b1;
      end
      S_DEMOTE: begin
        we        = do_demote;
        wa        = cur_task_r;
        wd        = cur_ent_r;
        wd.status = ST_READY;
      end
      S_PROMOTE: begin
        we        = found_r;
        wa        = best_r;
        wd        = best_ent_r;
        wd.status = ST_RUNNING;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_req) state_nxt = S_WALK;
      S_WALK:    if (pk_r == slot_t'(TASK_SLOTS - 1)) state_nxt = S_DEMOTE;
      S_DEMOTE:  state_nxt = S_PROMOTE;
      S_PROMOTE: state_nxt = S_OUT;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[rd_addr];
  end

  // Valid bits and the read-side copy of them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_task_r   <= '0;
      cur_valid_r  <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WALK) begin
        cnt_r <= cnt_nxt;
      end
      if (state_r == S_PROMOTE) begin
        cur_valid_r <= found_r;
        if (found_r) begin
          cur_task_r <= best_r;
        end
      end
      // A new result is loaded when the stage is free, else a taken one is dropped.
      if ((state_r == S_OUT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Request latch, walk index and selection tracking.
  always_ff @(posedge clk) begin
    if (in_req) begin
      ev_mode_r       <= mode_t'(in_tuser);
      ev_id_r         <= in_tdata[2:0];
      ev_prio_r       <= in_tdata[10:3];
      ev_dly_r        <= in_tdata[26:11];
      pk_r            <= '0;
      found_r         <= 1'b0;
      best_r          <= '0;
      best_ent_r      <= ENTRY_RESET;
      cur_ent_r       <= ENTRY_RESET;
    end else if (state_r == S_WALK) begin
      pk_r <= slot_t'(pk_r + 1'b1);
      if (elig) begin
        found_r    <= 1'b1;
        best_r     <= pk_r;
        best_ent_r <= upd;
      end
      if (pk_r == cur_task_r) begin
        cur_ent_r <= upd;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_data_r <= {3'b000, (cnt_r != '0), found_r,
                     (found_r ? 3'(best_r) : 3'b000)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // The running task always refers to an entry that has been written.
  a_cur_written: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> vld_r[cur_task_r])
    else $error("running task refers to an unwritten table entry");

  // The waiting count never exceeds the number of slots.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= TASK_SLOTS)
    else $error("waiting count out of range");

  // An accepted request always starts a table walk at entry zero.
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_req |=> (state_r == S_WALK) && (pk_r == '0))
    else $error("table walk did not start after a request");

  // A result is presented once the output stage is free.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && !out_tvalid_r |=> out_tvalid_r)
    else $error("result not presented");

  // A selected task is never one with the never-run priority.
  a_best_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROMOTE) && found_r |-> (best_ent_r.prio != PRIO_NEVER))
    else $error("task with never-run priority selected");
`endif

endmodule
